// File: hdl/gpio_port_pin_config_block_macros.svh
// ----------------------------------------------------------------------------
// GPIO port bank assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef GPIO_PORT_PIN_CONFIG_BLOCK_MACROS_SVH
`define GPIO_PORT_PIN_CONFIG_BLOCK_MACROS_SVH

// same-cycle implication
`define GPCB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GPCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/gpcb_pkg.sv
// ----------------------------------------------------------------------------
// gpcb_pkg
// Constants, request/status codes and the per-port register set type of the
// GPIO port bank.
// ----------------------------------------------------------------------------
package gpcb_pkg;

    localparam int PORT_COUNT_DEF = 6;
    localparam int PINS_PER_PORT  = 16;

    // action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_LOCK  = 2'd2;

    // register kinds
    localparam logic [3:0] KIND_MODE    = 4'd0;
    localparam logic [3:0] KIND_OTYPE   = 4'd1;
    localparam logic [3:0] KIND_SPEED   = 4'd2;
    localparam logic [3:0] KIND_PULL    = 4'd3;
    localparam logic [3:0] KIND_INPUT   = 4'd4;
    localparam logic [3:0] KIND_OUTPUT  = 4'd5;
    localparam logic [3:0] KIND_SETRST  = 4'd6;
    localparam logic [3:0] KIND_AF_LOW  = 4'd7;
    localparam logic [3:0] KIND_AF_HIGH = 4'd8;

    // result status
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_LOCKED = 2'd2;

    typedef struct packed {
        logic [31:0]              mode;
        logic [PINS_PER_PORT-1:0] otype;
        logic [31:0]              speed;
        logic [31:0]              pull;
        logic [PINS_PER_PORT-1:0] odata;
        logic [31:0]              af_low;
        logic [31:0]              af_high;
        logic [PINS_PER_PORT-1:0] lock_mask;
        logic                     lock_key;
    } port_cfg_t;

endpackage

// File: hdl/gpio_port_pin_config_block.sv
// ----------------------------------------------------------------------------
// gpio_port_pin_config_block
// Bank of GPIO ports with per-pin field writes, bit reads and a lock key.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready) carries action, port_number,
//   register_kind, pin_number, field_value and the sampled input_levels of
//   the addressed port. Result channel (out_valid/out_ready) returns status,
//   read_bit, lock_ok and the port's output data after the request.
//   A request is held in the input register; the read-modify-write of the
//   port's register set and the result are done there; the result then goes to
//   the result register. One request is taken per cycle unless a low out_ready
//   holds the result register; the port entry read and write in the same cycle
//   is what allows it, since the next request sees the updated state.
//   If out_ready is low the result register holds; one more request can
//   wait in the input register, after which in_ready drops.
//   Reset clears all port registers (all zero, unlocked) and empties both
//   stages. A lock holds until the next reset.
// ----------------------------------------------------------------------------
`include "gpio_port_pin_config_block_macros.svh"

module gpio_port_pin_config_block #(
    parameter int PORT_COUNT = gpcb_pkg::PORT_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [2:0]  port_number,
    input  logic [3:0]  register_kind,
    input  logic [3:0]  pin_number,
    input  logic [3:0]  field_value,
    input  logic [15:0] input_levels,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        read_bit,
    output logic        lock_ok,
    output logic [15:0] output_levels
);

    localparam int         IDX_W      = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam logic [3:0] PORT_LIMIT = 4'(PORT_COUNT);

    // input stage
    logic        s1_valid_reg;
    logic [1:0]  act_reg;
    logic [2:0]  port_reg;
    logic [3:0]  kind_reg;
    logic [3:0]  pin_reg;
    logic [3:0]  val_reg;
    logic [15:0] lvl_reg;

    // result stage
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic        rbit_reg;
    logic        lok_reg;
    logic [15:0] outlv_reg;

    gpcb_pkg::port_cfg_t cfg_reg [PORT_COUNT];

    logic                adv;
    logic                fire;
    logic                port_ok;
    logic [IDX_W-1:0]    idx;
    gpcb_pkg::port_cfg_t cur;
    gpcb_pkg::port_cfg_t port_next;
    logic                locked;
    logic                is_cfg;
    logic                legal;
    logic                commit;
    logic [4:0]          sh2;
    logic [4:0]          sh4;
    logic [31:0]         mask2;
    logic [31:0]         fld2;
    logic [31:0]         mask4;
    logic [31:0]         fld4;
    logic [1:0]          status_next;
    logic                rbit_next;
    logic                lok_next;
    logic [15:0]         outlv_next;

    function automatic logic register_kind_cfg(input logic [3:0] kind);
        logic r;
        r = kind inside {gpcb_pkg::KIND_MODE, gpcb_pkg::KIND_OTYPE, gpcb_pkg::KIND_SPEED,
                         gpcb_pkg::KIND_PULL, gpcb_pkg::KIND_AF_LOW, gpcb_pkg::KIND_AF_HIGH};
        return r;
    endfunction

    assign adv      = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && adv;
    assign in_ready = !s1_valid_reg || adv;

    assign port_ok = {1'b0, port_reg} < PORT_LIMIT;
    assign idx     = port_reg[IDX_W-1:0];
    assign cur     = cfg_reg[idx];
    assign locked  = cur.lock_key && cur.lock_mask[pin_reg];

    assign sh2   = {pin_reg, 1'b0};
    assign sh4   = {pin_reg[2:0], 2'b00};   // same slot for low and high altfn
    assign mask2 = 32'h3 << sh2;
    assign fld2  = 32'(val_reg[1:0]) << sh2;
    assign mask4 = 32'hF << sh4;
    assign fld4  = 32'(val_reg) << sh4;

    always_comb
    begin
        is_cfg = register_kind_cfg(kind_reg);
        legal  = (kind_reg inside {gpcb_pkg::KIND_MODE, gpcb_pkg::KIND_OTYPE,
                                   gpcb_pkg::KIND_SPEED, gpcb_pkg::KIND_PULL,
                                   gpcb_pkg::KIND_OUTPUT, gpcb_pkg::KIND_SETRST})
              || (kind_reg == gpcb_pkg::KIND_AF_LOW  && !pin_reg[3])
              || (kind_reg == gpcb_pkg::KIND_AF_HIGH &&  pin_reg[3]);

        port_next   = cur;
        commit      = 1'b0;
        status_next = gpcb_pkg::ST_REJECT;
        rbit_next   = 1'b0;
        lok_next    = 1'b0;

        if (port_ok)
        begin
            case (act_reg)
                gpcb_pkg::ACT_WRITE:
                begin
                    if (!legal)
                    begin
                        status_next = gpcb_pkg::ST_REJECT;
                    end
                    else if (is_cfg && locked)
                    begin
                        status_next = gpcb_pkg::ST_LOCKED;
                    end
                    else
                    begin
                        status_next = gpcb_pkg::ST_DONE;
                        commit      = 1'b1;
                        case (kind_reg)
                            gpcb_pkg::KIND_MODE:
                                port_next.mode = (cur.mode & ~mask2) | fld2;
                            gpcb_pkg::KIND_OTYPE:
                                port_next.otype[pin_reg] = val_reg[0];
                            gpcb_pkg::KIND_SPEED:
                                port_next.speed = (cur.speed & ~mask2) | fld2;
                            gpcb_pkg::KIND_PULL:
                                port_next.pull = (cur.pull & ~mask2) | fld2;
                            gpcb_pkg::KIND_OUTPUT:
                                port_next.odata[pin_reg] = val_reg[0];
                            gpcb_pkg::KIND_SETRST:
                                // only a value of exactly one sets
                                port_next.odata[pin_reg] = (val_reg == 4'h1);
                            gpcb_pkg::KIND_AF_LOW:
                                port_next.af_low = (cur.af_low & ~mask4) | fld4;
                            gpcb_pkg::KIND_AF_HIGH:
                                port_next.af_high = (cur.af_high & ~mask4) | fld4;
                            default:
                                commit = 1'b0;
                        endcase
                    end
                end
                gpcb_pkg::ACT_READ:
                begin
                    status_next = gpcb_pkg::ST_DONE;
                    case (kind_reg)
                        gpcb_pkg::KIND_MODE:   rbit_next = cur.mode[{1'b0, pin_reg}];
                        gpcb_pkg::KIND_OTYPE:  rbit_next = cur.otype[pin_reg];
                        gpcb_pkg::KIND_SPEED:  rbit_next = cur.speed[{1'b0, pin_reg}];
                        gpcb_pkg::KIND_PULL:   rbit_next = cur.pull[{1'b0, pin_reg}];
                        gpcb_pkg::KIND_INPUT:  rbit_next = lvl_reg[pin_reg];
                        gpcb_pkg::KIND_OUTPUT: rbit_next = cur.odata[pin_reg];
                        default:               status_next = gpcb_pkg::ST_REJECT;
                    endcase
                end
                gpcb_pkg::ACT_LOCK:
                begin
                    // key sequence only takes once; afterwards mask is frozen
                    if (!cur.lock_key)
                    begin
                        port_next.lock_mask          = '0;
                        port_next.lock_mask[pin_reg] = 1'b1;
                        port_next.lock_key           = 1'b1;
                        commit                       = 1'b1;
                    end
                    status_next = gpcb_pkg::ST_DONE;
                    lok_next    = 1'b1;
                end
                default:
                begin
                    status_next = gpcb_pkg::ST_REJECT;
                end
            endcase
        end

        outlv_next = port_ok ? port_next.odata : 16'h0000;
    end

    // control and port state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                cfg_reg[p] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (fire && port_ok && commit)
            begin
                cfg_reg[idx] <= port_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg  <= action;
            port_reg <= port_number;
            kind_reg <= register_kind;
            pin_reg  <= pin_number;
            val_reg  <= field_value;
            lvl_reg  <= input_levels;
        end
        if (fire)
        begin
            status_reg <= status_next;
            rbit_reg   <= rbit_next;
            lok_reg    <= lok_next;
            outlv_reg  <= outlv_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign read_bit      = rbit_reg;
    assign lock_ok       = lok_reg;
    assign output_levels = outlv_reg;

    // checks
    for (genvar g = 0; g < PORT_COUNT; g++)
    begin : gen_chk
        `GPCB_ASSERT_NEXT(a_key_sticky, cfg_reg[g].lock_key, cfg_reg[g].lock_key, "lock key cleared")
        `GPCB_ASSERT_NEXT(a_mask_frozen, cfg_reg[g].lock_key, $stable(cfg_reg[g].lock_mask), "locked mask changed")
        `GPCB_ASSERT_NOW(a_mask_onehot, cfg_reg[g].lock_key, $onehot(cfg_reg[g].lock_mask), "lock mask not one pin")
    end

    `GPCB_ASSERT_NEXT(a_result_follows, s1_valid_reg && adv, out_valid_reg, "item lost between stages")
    `GPCB_ASSERT_NOW(a_flags_on_done, out_valid_reg && status_reg != gpcb_pkg::ST_DONE, !rbit_reg && !lok_reg, "flag set on failed request")

endmodule
